// ===== hw/rtl/srpr_pkg.sv =====
// shared types and constants for the spi register port with receive fifo
package srpr_pkg;

  localparam int unsigned IDX_W   = 4;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [IDX_W-1:0] IDX_CR2 = 4'd1;
  localparam logic [IDX_W-1:0] IDX_SR  = 4'd2;
  localparam logic [IDX_W-1:0] IDX_DR  = 4'd3;

  localparam int unsigned BIT_RXNE    = 0;
  localparam int unsigned BIT_TXE     = 1;
  localparam int unsigned BIT_DMA_RX  = 0;
  localparam int unsigned BIT_DMA_TX  = 1;
  localparam int unsigned BIT_IRQ_RX  = 6;
  localparam int unsigned BIT_IRQ_TX  = 7;

  localparam logic [31:0] SR_RESET = 32'h0000_0002;

  typedef enum logic [1:0] {
    MODE_ZERO    = 2'd0,
    MODE_ECHO    = 2'd1,
    MODE_PARTNER = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_RD_DR   = 3'd1,
    OP_RD_REG  = 3'd2,
    OP_WR_DR   = 3'd3,
    OP_WR_CR2  = 3'd4,
    OP_WR_REG  = 3'd5
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic [2:0]       rd_bytes;
    logic [3:0]       rd_lanes;
    logic [31:0]      wdata;
    logic [3:0]       be;
    logic             two;
    logic [7:0]       rx0;
    logic [7:0]       rx1;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  status_word;
    logic        irq_pulse;
    logic        dma_rx_pulse;
    logic        dma_tx_pulse;
    logic        rx_overflow;
  } result_t;

  // one byte of mask per enabled lane
  function automatic logic [31:0] lanes_to_mask(logic [3:0] lanes);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      m[8*k +: 8] = {8{lanes[k]}};
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/srpr_queue.sv =====
// two-entry queue of packed words, used between front, back and result side
module srpr_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [srpr_pkg::QDEPTH];
  logic [srpr_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [srpr_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [srpr_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == srpr_pkg::QCNT_W'(srpr_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + srpr_pkg::QPTR_W'(do_push);
    rd_ptr_d = rd_ptr_q + srpr_pkg::QPTR_W'(do_pop);
    cnt_d    = cnt_q + srpr_pkg::QCNT_W'(do_push) - srpr_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/srpr_front.sv =====
// front end: holds the reply mode and classifies each bus transaction
module srpr_front #(
  parameter int unsigned REG_WORDS = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_data_i,
  input  logic                           req_type_i,
  input  logic [srpr_pkg::IDX_W-1:0]     reg_index_i,
  input  logic [2:0]                     access_bytes_i,
  input  logic [31:0]                    write_data_i,
  input  logic [3:0]                     byte_enable_i,
  input  logic [7:0]                     partner_byte0_i,
  input  logic [7:0]                     partner_byte1_i,
  input  logic [1:0]                     partner_count_i,
  output srpr_pkg::cmd_t                 cmd_o
);

  logic [1:0] reply_mode_q;
  logic       idx_ok;
  logic [2:0] bytes_c;
  logic [1:0] pcount_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_mode_q <= 2'(srpr_pkg::MODE_ZERO);
    end else if (cfg_we_i) begin
      reply_mode_q <= cfg_data_i;
    end
  end

  assign idx_ok   = ({1'b0, reg_index_i} < 5'(REG_WORDS));
  assign bytes_c  = (access_bytes_i > 3'd4) ? 3'd4 : access_bytes_i;
  assign pcount_c = (partner_count_i == 2'd3) ? 2'd2 : partner_count_i;

  always_comb begin
    cmd_o.idx      = reg_index_i;
    cmd_o.rd_bytes = bytes_c;
    cmd_o.wdata    = write_data_i;
    cmd_o.be       = byte_enable_i;
    cmd_o.two      = |byte_enable_i[3:1];
    unique case (bytes_c)
      3'd0:    cmd_o.rd_lanes = 4'b0000;
      3'd1:    cmd_o.rd_lanes = 4'b0001;
      3'd2:    cmd_o.rd_lanes = 4'b0011;
      3'd3:    cmd_o.rd_lanes = 4'b0111;
      default: cmd_o.rd_lanes = 4'b1111;
    endcase

    // source of the received bytes
    unique case (srpr_pkg::mode_e'(reply_mode_q))
      srpr_pkg::MODE_ECHO: begin
        cmd_o.rx0 = write_data_i[7:0];
        cmd_o.rx1 = write_data_i[15:8];
      end
      srpr_pkg::MODE_PARTNER: begin
        cmd_o.rx0 = (pcount_c >= 2'd1) ? partner_byte0_i : 8'd0;
        cmd_o.rx1 = (pcount_c >= 2'd2) ? partner_byte1_i : 8'd0;
      end
      default: begin
        cmd_o.rx0 = 8'd0;
        cmd_o.rx1 = 8'd0;
      end
    endcase

    if (!idx_ok) begin
      cmd_o.op = srpr_pkg::OP_NONE;
    end else if (!req_type_i) begin
      cmd_o.op = (reg_index_i == srpr_pkg::IDX_DR) ? srpr_pkg::OP_RD_DR
                                                   : srpr_pkg::OP_RD_REG;
    end else if (reg_index_i == srpr_pkg::IDX_SR) begin
      cmd_o.op = srpr_pkg::OP_NONE;
    end else if (reg_index_i == srpr_pkg::IDX_DR) begin
      cmd_o.op = srpr_pkg::OP_WR_DR;
    end else if (reg_index_i == srpr_pkg::IDX_CR2) begin
      cmd_o.op = srpr_pkg::OP_WR_CR2;
    end else begin
      cmd_o.op = srpr_pkg::OP_WR_REG;
    end
  end

endmodule

// ===== hw/rtl/srpr_back.sv =====
// back end: register words, receive byte fifo and request pulse logic
module srpr_back #(
  parameter int unsigned RX_FIFO_DEPTH = 8,
  parameter int unsigned REG_WORDS     = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  srpr_pkg::cmd_t      cmd_i,
  input  logic                res_full_i,
  output logic                take_o,
  output srpr_pkg::result_t   res_o
);

  localparam int unsigned FW = $clog2(RX_FIFO_DEPTH + 1);
  localparam int unsigned IW = $clog2(REG_WORDS);
  localparam int unsigned CW = (FW > 3) ? FW : 3;
  localparam logic [FW-1:0] DepthF  = FW'(RX_FIFO_DEPTH);
  localparam logic [FW:0]   DepthF1 = (FW+1)'(RX_FIFO_DEPTH);

  logic [31:0]   regs_q [REG_WORDS];
  logic [7:0]    fifo_q [RX_FIFO_DEPTH];
  logic [7:0]    fifo_d [RX_FIFO_DEPTH];
  logic [FW-1:0] fill_q, fill_d;

  logic [IW-1:0] idx_w;
  logic [IW-1:0] reg_widx;
  logic          reg_we;
  logic [31:0]   reg_wdata;
  logic [31:0]   merged;
  logic [31:0]   cr2_val;
  logic [31:0]   rd_data;
  logic [31:0]   status_pre;
  logic [2:0]    pop_n;
  logic [FW:0]   fill_p1;
  logic          first_ok, second_ok;
  logic          ovf, sig, rxne;

  assign take_o     = cmd_valid_i && !res_full_i;
  assign idx_w      = cmd_i.idx[IW-1:0];
  assign merged     = (regs_q[idx_w] & ~srpr_pkg::lanes_to_mask(cmd_i.be))
                    | (cmd_i.wdata & srpr_pkg::lanes_to_mask(cmd_i.be));
  assign status_pre = srpr_pkg::SR_RESET | {31'd0, (fill_q != '0)};
  assign fill_p1    = {1'b0, fill_q} + (FW+1)'(1);
  assign first_ok   = (fill_q < DepthF);
  assign second_ok  = cmd_i.two && (fill_p1 < DepthF1);
  assign pop_n      = (CW'(fill_q) < CW'(cmd_i.rd_bytes)) ? 3'(fill_q) : cmd_i.rd_bytes;

  always_comb begin
    fifo_d    = fifo_q;
    fill_d    = fill_q;
    rd_data   = '0;
    ovf       = 1'b0;
    sig       = 1'b0;
    reg_we    = 1'b0;
    reg_widx  = idx_w;
    reg_wdata = merged;
    cr2_val   = regs_q[IW'(srpr_pkg::IDX_CR2)];

    unique case (cmd_i.op)
      srpr_pkg::OP_RD_DR: begin
        // pop up to four bytes from the head, little-endian
        for (int k = 0; k < 4; k++) begin
          if (k < RX_FIFO_DEPTH && 3'(k) < pop_n) begin
            rd_data[8*k +: 8] = fifo_q[k % RX_FIFO_DEPTH];
          end
        end
        for (int i = 0; i < RX_FIFO_DEPTH; i++) begin
          for (int j = 1; j < 5; j++) begin
            if (pop_n == 3'(j) && i + j < RX_FIFO_DEPTH) begin
              fifo_d[i] = fifo_q[(i + j) % RX_FIFO_DEPTH];
            end
          end
        end
        fill_d    = fill_q - FW'(pop_n);
        reg_we    = 1'b1;
        reg_widx  = IW'(srpr_pkg::IDX_DR);
        reg_wdata = rd_data;
        sig       = 1'b1;
      end
      srpr_pkg::OP_RD_REG: begin
        rd_data = ((cmd_i.idx == srpr_pkg::IDX_SR) ? status_pre : regs_q[idx_w])
                & srpr_pkg::lanes_to_mask(cmd_i.rd_lanes);
      end
      srpr_pkg::OP_WR_DR: begin
        for (int i = 0; i < RX_FIFO_DEPTH; i++) begin
          if (first_ok && FW'(i) == fill_q) begin
            fifo_d[i] = cmd_i.rx0;
          end
          if (second_ok && (FW+1)'(i) == fill_p1) begin
            fifo_d[i] = cmd_i.rx1;
          end
        end
        fill_d = fill_q + FW'(first_ok) + FW'(second_ok);
        ovf    = !first_ok || (cmd_i.two && !second_ok);
        reg_we = 1'b1;
        sig    = 1'b1;
      end
      srpr_pkg::OP_WR_CR2: begin
        reg_we  = 1'b1;
        cr2_val = merged;
        sig     = 1'b1;
      end
      srpr_pkg::OP_WR_REG: begin
        reg_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rxne = (fill_d != '0);

  always_comb begin
    res_o.read_data    = rd_data;
    res_o.status_word  = srpr_pkg::SR_RESET[7:0] | {7'd0, rxne};
    res_o.irq_pulse    = sig && ((cr2_val[srpr_pkg::BIT_IRQ_RX] && rxne)
                               || cr2_val[srpr_pkg::BIT_IRQ_TX]);
    res_o.dma_rx_pulse = sig && cr2_val[srpr_pkg::BIT_DMA_RX] && rxne;
    res_o.dma_tx_pulse = sig && cr2_val[srpr_pkg::BIT_DMA_TX];
    res_o.rx_overflow  = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      for (int w = 0; w < REG_WORDS; w++) begin
        regs_q[w] <= (IW'(w) == IW'(srpr_pkg::IDX_SR)) ? srpr_pkg::SR_RESET : 32'd0;
      end
    end else if (take_o) begin
      fill_q <= fill_d;
      if (reg_we) begin
        regs_q[reg_widx] <= reg_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      fifo_q <= fifo_d;
    end
  end

endmodule

// ===== hw/rtl/spi_register_port_rx_fifo.sv =====
// top level of the spi register port with receive byte fifo
// transactions wait in the command queue, results in the result queue that feeds the output ports
// throughput: one transaction per cycle while the result queue has room for its result
// the back end stalls only while the two-entry result queue is full
// reset: async active low; clears queues, fifo fill, register words and reply mode
// no clearing pass: fifo bytes are only read after being written
module spi_register_port_rx_fifo #(
  parameter int unsigned RX_FIFO_DEPTH = 8,
  parameter int unsigned REG_WORDS     = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: reply mode
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_data_i,
  // request side
  input  logic                       push,
  output logic                       full,
  input  logic                       req_type_i,
  input  logic [srpr_pkg::IDX_W-1:0] reg_index_i,
  input  logic [2:0]                 access_bytes_i,
  input  logic [31:0]                write_data_i,
  input  logic [3:0]                 byte_enable_i,
  input  logic [7:0]                 partner_byte0_i,
  input  logic [7:0]                 partner_byte1_i,
  input  logic [1:0]                 partner_count_i,
  // result side
  output logic                       empty,
  input  logic                       pop,
  output logic [31:0]                read_data_o,
  output logic [7:0]                 status_word_o,
  output logic                       irq_pulse_o,
  output logic                       dma_rx_pulse_o,
  output logic                       dma_tx_pulse_o,
  output logic                       rx_overflow_o
);

  srpr_pkg::cmd_t    cmd_in, cmd_out;
  srpr_pkg::result_t res_in, res_out;
  logic              cmd_empty;
  logic              res_full;
  logic              take;

  // decode the transaction and fold in the reply source
  srpr_front #(
    .REG_WORDS (REG_WORDS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .reg_index_i     (reg_index_i),
    .access_bytes_i  (access_bytes_i),
    .write_data_i    (write_data_i),
    .byte_enable_i   (byte_enable_i),
    .partner_byte0_i (partner_byte0_i),
    .partner_byte1_i (partner_byte1_i),
    .partner_count_i (partner_count_i),
    .cmd_o           (cmd_in)
  );

  // decoded transactions waiting for the back end
  srpr_queue #(
    .WIDTH ($bits(srpr_pkg::cmd_t))
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (take),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // state update and result formation
  srpr_back #(
    .RX_FIFO_DEPTH (RX_FIFO_DEPTH),
    .REG_WORDS     (REG_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .res_full_i  (res_full),
    .take_o      (take),
    .res_o       (res_in)
  );

  // finished results, oldest on the output ports
  srpr_queue #(
    .WIDTH ($bits(srpr_pkg::result_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign read_data_o    = res_out.read_data;
  assign status_word_o  = res_out.status_word;
  assign irq_pulse_o    = res_out.irq_pulse;
  assign dma_rx_pulse_o = res_out.dma_rx_pulse;
  assign dma_tx_pulse_o = res_out.dma_tx_pulse;
  assign rx_overflow_o  = res_out.rx_overflow;

endmodule

// ===== hw/rtl/srpr_checker.sv =====
// port-level checks for the spi register port, bound to the top level
module srpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] read_data_o,
  input logic [7:0]  status_word_o,
  input logic        dma_rx_pulse_o,
  input logic        rx_overflow_o
);

  // transmit empty is always reported and the upper status bits stay clear
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_word_o[7:2] == 6'd0 && status_word_o[1]))
    else $error("status word shape wrong");

  // a dropped byte means the fifo was full, so it cannot be empty afterwards
  a_ovf_rxne: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rx_overflow_o) |-> status_word_o[0])
    else $error("overflow without rxne");

  // receive dma request needs a non-empty fifo
  a_drx_rxne: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && dma_rx_pulse_o) |-> status_word_o[0])
    else $error("rx dma request without rxne");

  // a waiting result is held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(read_data_o) && $stable(status_word_o)))
    else $error("result changed while waiting");

endmodule

bind spi_register_port_rx_fifo srpr_checker u_srpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .read_data_o    (read_data_o),
  .status_word_o  (status_word_o),
  .dma_rx_pulse_o (dma_rx_pulse_o),
  .rx_overflow_o  (rx_overflow_o)
);

// ===== tb/tb_spi_register_port_rx_fifo.sv =====
// testbench for the spi register port with receive byte fifo
module tb_spi_register_port_rx_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RX_DEPTH  = 8;
  localparam int unsigned NUM_WORDS = 9;
  localparam int unsigned MAX_CYCLES = 400000;

  // request kinds and the reply mode that the enum leaves out
  localparam logic       REQ_READ    = 1'b0;
  localparam logic       REQ_WRITE   = 1'b1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // one bus access as it appears on the request ports
  typedef struct {
    logic                       req_type;
    logic [srpr_pkg::IDX_W-1:0] reg_index;
    logic [2:0]                 access_bytes;
    logic [31:0]                write_data;
    logic [3:0]                 byte_enable;
    logic [7:0]                 partner_byte0;
    logic [7:0]                 partner_byte1;
    logic [1:0]                 partner_count;
  } bus_access_t;

  // tracks register words, the receive fifo and the reply mode, and holds
  // the replies still owed by the block, oldest first
  class reg_port_scoreboard;
    logic [31:0]        regs[NUM_WORDS];
    logic [7:0]         rx_bytes[RX_DEPTH];
    int unsigned        rx_count;
    int unsigned        rx_rd_ptr;
    logic [1:0]         rx_src;
    srpr_pkg::result_t  reply_q[$];
    int unsigned        errors;
    int unsigned        accesses;
    int unsigned        checked;
    int unsigned        drops;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[srpr_pkg::IDX_SR] = srpr_pkg::SR_RESET;
      rx_count  = 0;
      rx_rd_ptr = 0;
      rx_src    = srpr_pkg::MODE_ZERO;
      errors    = 0;
      accesses  = 0;
      checked   = 0;
      drops     = 0;
    endfunction

    function int unsigned pending();
      return reply_q.size();
    endfunction

    // sr always shows txe, rxne follows the fifo fill
    function logic [31:0] refresh_status();
      logic [31:0] s;
      s = regs[srpr_pkg::IDX_SR];
      s[srpr_pkg::BIT_TXE]  = 1'b1;
      s[srpr_pkg::BIT_RXNE] = (rx_count != 0);
      regs[srpr_pkg::IDX_SR] = s;
      return s;
    endfunction

    function void note_access(bus_access_t a);
      srpr_pkg::result_t res;
      logic [31:0] rdata;
      logic [31:0] lanes;
      logic [31:0] s;
      logic [31:0] c;
      logic [7:0]  tx;
      logic [7:0]  rx;
      logic [7:0]  partner[2];
      logic        signal;
      logic        ovf;
      int unsigned width;
      int unsigned pcount;
      int unsigned nbytes;

      res     = '0;
      rdata   = '0;
      signal  = 1'b0;
      ovf     = 1'b0;
      partner[0] = a.partner_byte0;
      partner[1] = a.partner_byte1;
      width  = (a.access_bytes > 4) ? 4 : a.access_bytes;
      pcount = (a.partner_count > 2) ? 2 : a.partner_count;
      accesses++;

      if (a.reg_index < NUM_WORDS) begin
        if (a.req_type == REQ_READ) begin
          if (a.reg_index == srpr_pkg::IDX_DR) begin
            // pop as many bytes as the width allows, little-endian
            for (int k = 0; k < width && rx_count != 0; k++) begin
              rdata[8*k +: 8] = rx_bytes[rx_rd_ptr];
              rx_rd_ptr = (rx_rd_ptr + 1) % RX_DEPTH;
              rx_count--;
            end
            regs[srpr_pkg::IDX_DR] = rdata;
            signal = 1'b1;
          end else begin
            void'(refresh_status());
            rdata = regs[a.reg_index];
            if (width < 4) rdata &= (32'd1 << (8 * width)) - 32'd1;
          end
        end else if (a.reg_index != srpr_pkg::IDX_SR) begin
          lanes = '0;
          for (int k = 0; k < 4; k++) begin
            if (a.byte_enable[k]) lanes[8*k +: 8] = 8'hff;
          end
          regs[a.reg_index] = (regs[a.reg_index] & ~lanes) | (a.write_data & lanes);
          if (a.reg_index == srpr_pkg::IDX_DR) begin
            nbytes = (a.byte_enable[3:1] != 3'b000) ? 2 : 1;
            for (int k = 0; k < nbytes; k++) begin
              tx = a.write_data[8*k +: 8];
              rx = 8'h00;
              if (rx_src == srpr_pkg::MODE_ECHO) rx = tx;
              else if (rx_src == srpr_pkg::MODE_PARTNER && k < pcount) rx = partner[k];
              if (rx_count >= RX_DEPTH) begin
                ovf = 1'b1;
                drops++;
              end else begin
                rx_bytes[(rx_rd_ptr + rx_count) % RX_DEPTH] = rx;
                rx_count++;
              end
            end
            signal = 1'b1;
          end else if (a.reg_index == srpr_pkg::IDX_CR2) begin
            signal = 1'b1;
          end
        end
      end

      s = refresh_status();
      if (signal) begin
        c = regs[srpr_pkg::IDX_CR2];
        res.irq_pulse    = (c[srpr_pkg::BIT_IRQ_RX] && s[srpr_pkg::BIT_RXNE])
                         || (c[srpr_pkg::BIT_IRQ_TX] && s[srpr_pkg::BIT_TXE]);
        res.dma_rx_pulse = c[srpr_pkg::BIT_DMA_RX] && s[srpr_pkg::BIT_RXNE];
        res.dma_tx_pulse = c[srpr_pkg::BIT_DMA_TX] && s[srpr_pkg::BIT_TXE];
      end
      res.read_data   = (a.req_type == REQ_WRITE) ? 32'h0 : rdata;
      res.status_word = s[7:0];
      res.rx_overflow = ovf;
      reply_q = {reply_q, res};
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(srpr_pkg::result_t got);
      srpr_pkg::result_t want;
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t ns: reply with none expected, actual read_data 0x%0h status 0x%0h",
                 $time, got.read_data, got.status_word);
        return;
      end
      want = reply_q[0];
      reply_q.delete(0);
      checked++;
      compare("read_data", want.read_data, got.read_data);
      compare("status_word", want.status_word, got.status_word);
      compare("irq_pulse", want.irq_pulse, got.irq_pulse);
      compare("dma_rx_pulse", want.dma_rx_pulse, got.dma_rx_pulse);
      compare("dma_tx_pulse", want.dma_tx_pulse, got.dma_tx_pulse);
      compare("rx_overflow", want.rx_overflow, got.rx_overflow);
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [1:0]                 cfg_data_i;
  logic                       push;
  logic                       full;
  logic                       req_type_i;
  logic [srpr_pkg::IDX_W-1:0] reg_index_i;
  logic [2:0]                 access_bytes_i;
  logic [31:0]                write_data_i;
  logic [3:0]                 byte_enable_i;
  logic [7:0]                 partner_byte0_i;
  logic [7:0]                 partner_byte1_i;
  logic [1:0]                 partner_count_i;
  logic                       empty;
  logic                       pop;
  logic [31:0]                read_data_o;
  logic [7:0]                 status_word_o;
  logic                       irq_pulse_o;
  logic                       dma_rx_pulse_o;
  logic                       dma_tx_pulse_o;
  logic                       rx_overflow_o;

  reg_port_scoreboard sb;
  bit                 idle_on;
  int unsigned        cycle_count;

  spi_register_port_rx_fifo #(
    .RX_FIFO_DEPTH(RX_DEPTH),
    .REG_WORDS    (NUM_WORDS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .reg_index_i    (reg_index_i),
    .access_bytes_i (access_bytes_i),
    .write_data_i   (write_data_i),
    .byte_enable_i  (byte_enable_i),
    .partner_byte0_i(partner_byte0_i),
    .partner_byte1_i(partner_byte1_i),
    .partner_count_i(partner_count_i),
    .empty          (empty),
    .pop            (pop),
    .read_data_o    (read_data_o),
    .status_word_o  (status_word_o),
    .irq_pulse_o    (irq_pulse_o),
    .dma_rx_pulse_o (dma_rx_pulse_o),
    .dma_tx_pulse_o (dma_tx_pulse_o),
    .rx_overflow_o  (rx_overflow_o)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d replies still owed", cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sample both handshakes and config writes at the edge, before the
  // drivers' nonblocking updates land
  always @(posedge clk_i) begin : bus_monitor
    bus_access_t       seen;
    srpr_pkg::result_t got;
    if (cfg_we_i) sb.rx_src = cfg_data_i;
    if (push && !full) begin
      seen.req_type      = req_type_i;
      seen.reg_index     = reg_index_i;
      seen.access_bytes  = access_bytes_i;
      seen.write_data    = write_data_i;
      seen.byte_enable   = byte_enable_i;
      seen.partner_byte0 = partner_byte0_i;
      seen.partner_byte1 = partner_byte1_i;
      seen.partner_count = partner_count_i;
      sb.note_access(seen);
    end
    if (pop && !empty) begin
      got.read_data    = read_data_o;
      got.status_word  = status_word_o;
      got.irq_pulse    = irq_pulse_o;
      got.dma_rx_pulse = dma_rx_pulse_o;
      got.dma_tx_pulse = dma_tx_pulse_o;
      got.rx_overflow  = rx_overflow_o;
      sb.check_reply(got);
    end
  end

  // result side: pop held high, dropped at random while idling is enabled
  initial begin : result_side
    int unsigned hold;
    hold = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) hold--;
      else if (idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 19);
      pop <= (hold == 0);
    end
  end

  // present one transaction and hold it until accepted, then maybe idle
  task automatic send(bus_access_t a);
    push            <= 1'b1;
    req_type_i      <= a.req_type;
    reg_index_i     <= a.reg_index;
    access_bytes_i  <= a.access_bytes;
    write_data_i    <= a.write_data;
    byte_enable_i   <= a.byte_enable;
    partner_byte0_i <= a.partner_byte0;
    partner_byte1_i <= a.partner_byte1;
    partner_count_i <= a.partner_count;
    do @(posedge clk_i); while (full);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // read with junk in the write-only fields
  task automatic rd(logic [srpr_pkg::IDX_W-1:0] idx, logic [2:0] nbytes);
    bus_access_t a;
    a.req_type      = REQ_READ;
    a.reg_index     = idx;
    a.access_bytes  = nbytes;
    a.write_data    = $urandom;
    a.byte_enable   = $urandom_range(0, 15);
    a.partner_byte0 = $urandom_range(0, 255);
    a.partner_byte1 = $urandom_range(0, 255);
    a.partner_count = $urandom_range(0, 3);
    send(a);
  endtask

  task automatic wr(logic [srpr_pkg::IDX_W-1:0] idx, logic [31:0] data, logic [3:0] be,
                    logic [7:0] p0 = 8'h00, logic [7:0] p1 = 8'h00, logic [1:0] pc = 2'd0);
    bus_access_t a;
    a.req_type      = REQ_WRITE;
    a.reg_index     = idx;
    a.access_bytes  = $urandom_range(0, 7);
    a.write_data    = data;
    a.byte_enable   = be;
    a.partner_byte0 = p0;
    a.partner_byte1 = p1;
    a.partner_count = pc;
    send(a);
  endtask

  // mostly data register traffic so the fifo fills and drains
  function automatic bus_access_t random_access(int unsigned write_pct);
    bus_access_t a;
    int unsigned pick;
    a.req_type = ($urandom_range(0, 99) < write_pct) ? REQ_WRITE : REQ_READ;
    pick = $urandom_range(0, 19);
    if (pick < 13)       a.reg_index = srpr_pkg::IDX_DR;
    else if (pick < 15)  a.reg_index = srpr_pkg::IDX_CR2;
    else if (pick == 15) a.reg_index = srpr_pkg::IDX_SR;
    else                 a.reg_index = $urandom_range(0, 15);
    case ($urandom_range(0, 3))
      0:       a.access_bytes = $urandom_range(0, 7);
      1:       a.access_bytes = 3'd1;
      2:       a.access_bytes = 3'd2;
      default: a.access_bytes = 3'd4;
    endcase
    a.write_data    = $urandom;
    a.byte_enable   = $urandom_range(0, 15);
    a.partner_byte0 = $urandom_range(0, 255);
    a.partner_byte1 = $urandom_range(0, 255);
    a.partner_count = $urandom_range(0, 3);
    return a;
  endfunction

  // drain every owed reply, let the pipeline settle, then drive the register
  task automatic set_mode(logic [1:0] m);
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned write_pct;
    logic [1:0]  mode;

    sb              = new();
    idle_on         = 1'b1;
    cycle_count     = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    push            = 1'b0;
    req_type_i      = REQ_READ;
    reg_index_i     = '0;
    access_bytes_i  = '0;
    write_data_i    = '0;
    byte_enable_i   = '0;
    partner_byte0_i = '0;
    partner_byte1_i = '0;
    partner_count_i = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values before any config write
    rd(4'd0, 3'd4);
    rd(srpr_pkg::IDX_SR, 3'd4);

    // echo mode: fill the fifo, overflow it, drain it with several widths
    set_mode(srpr_pkg::MODE_ECHO);
    wr(srpr_pkg::IDX_SR, 32'hffff_ffff, 4'hf);      // sr write is dropped
    wr(srpr_pkg::IDX_CR2, 32'hffff_ffff, 4'b0001);  // all irq and dma enables
    rd(srpr_pkg::IDX_CR2, 3'd7);                    // width above four
    wr(srpr_pkg::IDX_DR, 32'h0000_00a5, 4'b0001);   // single byte
    wr(srpr_pkg::IDX_DR, 32'hffff_5a3c, 4'b1000);   // upper lane only, two bytes
    repeat (3) wr(srpr_pkg::IDX_DR, $urandom, 4'hf); // fifo now full
    wr(srpr_pkg::IDX_DR, 32'h1234_5678, 4'b0000);   // dropped byte on full fifo
    rd(srpr_pkg::IDX_DR, 3'd0);                     // zero width pops nothing
    rd(srpr_pkg::IDX_DR, 3'd1);
    rd(srpr_pkg::IDX_DR, 3'd2);
    rd(srpr_pkg::IDX_DR, 3'd4);
    rd(srpr_pkg::IDX_DR, 3'd7);
    rd(srpr_pkg::IDX_DR, 3'd4);                     // read of an empty fifo
    wr(4'd8, 32'hdead_beef, 4'b1010);               // lane merge into the last word
    rd(4'd8, 3'd3);
    wr(4'd15, 32'hffff_ffff, 4'hf);                 // beyond the register file
    rd(4'd15, 3'd4);
    wr(srpr_pkg::IDX_CR2, 32'h0000_0000, 4'hf);

    // partner replies with counts 0 and 1 and the clamped count 3
    set_mode(srpr_pkg::MODE_PARTNER);
    wr(srpr_pkg::IDX_DR, 32'h0000_0000, 4'b0010, 8'h81, 8'h7e, 2'd3);
    wr(srpr_pkg::IDX_DR, 32'h0000_0000, 4'b0001, 8'hff, 8'hff, 2'd0);
    wr(srpr_pkg::IDX_DR, 32'h0000_0000, 4'b0100, 8'h11, 8'h22, 2'd1);
    rd(srpr_pkg::IDX_DR, 3'd4);

    // unused mode code receives zeros
    set_mode(MODE_UNUSED);
    wr(srpr_pkg::IDX_DR, 32'hffff_ffff, 4'hf, 8'hff, 8'hff, 2'd2);
    rd(srpr_pkg::IDX_DR, 3'd2);

    // random phases over all reply modes, with varying read/write balance;
    // the third phase and the last one run without idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       mode = srpr_pkg::MODE_ZERO;
        1, 4:    mode = srpr_pkg::MODE_ECHO;
        3:       mode = MODE_UNUSED;
        default: mode = srpr_pkg::MODE_PARTNER;
      endcase
      set_mode(mode);
      idle_on   = (ph != 2) && (ph != 5);
      write_pct = $urandom_range(35, 75);
      repeat (85) send(random_access(write_pct));
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d register accesses in four reply modes, %0d replies checked",
             sb.accesses, sb.checked);
    $display("fifo dropped %0d bytes on overflow, %0d mismatches", sb.drops, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/srpr_pkg.sv
hw/rtl/srpr_queue.sv
hw/rtl/srpr_front.sv
hw/rtl/srpr_back.sv
hw/rtl/spi_register_port_rx_fifo.sv
hw/rtl/srpr_checker.sv
tb/tb_spi_register_port_rx_fifo.sv
